### src/rd_pkg.sv
`default_nettype none

package rd_pkg;

  localparam int FRAC_BITS_DEF = 14;

  localparam int IN_W    = 16;
  localparam int IDX_W   = 16;
  localparam int OUT_W   = 18;
  localparam int VEC_W   = 6 * IN_W;

  localparam int S_DATA_W = 128;
  localparam int M_DATA_W = 56;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // The product of eta^2 and k saturates in magnitude at this power of two.
  localparam int SAT_SHIFT = 62;

  // Operand split used by the wide product of eta^2 and k.
  localparam int SPLIT = 26;

endpackage

`default_nettype wire

### src/rd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage, payload carried alongside.
module rd_div #(
  parameter int NW = 46,
  parameter int DW = 16,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vi,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [PW-1:0] pi,
  output logic               vo,
  output logic [NW-1:0]      quo,
  output logic [PW-1:0]      po
);

  logic [DW-1:0] rem [NW];
  logic [NW-1:0] nq  [NW];
  logic [DW-1:0] dn  [NW];
  logic [PW-1:0] pp  [NW];
  logic          vv  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW-1:0] rem_in;
    logic [DW-1:0] dn_in;
    logic [NW-1:0] nq_in;
    logic [PW-1:0] p_in;
    logic          v_in;
    logic [DW:0]   r2;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dn_in  = den;
      assign nq_in  = num;
      assign p_in   = pi;
      assign v_in   = vi;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dn_in  = dn[i-1];
      assign nq_in  = nq[i-1];
      assign p_in   = pp[i-1];
      assign v_in   = vv[i-1];
    end

    assign r2 = {rem_in, nq_in[NW-1]};
    assign ge = r2 >= {1'b0, dn_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i] <= 1'b0;
      end else if (en) begin
        vv[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? DW'(r2 - {1'b0, dn_in}) : r2[DW-1:0];
        nq[i]  <= {nq_in[NW-2:0], ge};
        dn[i]  <= dn_in;
        pp[i]  <= p_in;
      end
    end
  end

  assign vo  = vv[NW-1];
  assign quo = nq[NW-1];
  assign po  = pp[NW-1];

endmodule

`default_nettype wire

### src/rd_sqrt.sv
`default_nettype none

// Digit-by-digit integer square root, one root bit per stage.
// The root is truncated; the remainder is returned for rounding.
module rd_sqrt #(
  parameter int SW = 49,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vi,
  input  wire logic [SW-1:0] x,
  input  wire logic [PW-1:0] pi,
  output logic               vo,
  output logic [SW:0]        root,
  output logic [SW:0]        rem,
  output logic [PW-1:0]      po
);

  localparam int Q  = (SW + 1) / 2;
  localparam int XW = SW + 1;

  logic [XW-1:0] xr [Q];
  logic [XW-1:0] rr [Q];
  logic [PW-1:0] pp [Q];
  logic          vv [Q];

  for (genvar i = 0; i < Q; i++) begin : g_st
    localparam int SH = 2 * (Q - 1 - i);
    logic [XW-1:0] x_in;
    logic [XW-1:0] r_in;
    logic [PW-1:0] p_in;
    logic          v_in;
    logic [XW-1:0] bitv;
    logic [XW-1:0] t;
    logic          ge;

    if (i == 0) begin : g_first
      assign x_in = XW'(x);
      assign r_in = '0;
      assign p_in = pi;
      assign v_in = vi;
    end else begin : g_next
      assign x_in = xr[i-1];
      assign r_in = rr[i-1];
      assign p_in = pp[i-1];
      assign v_in = vv[i-1];
    end

    assign bitv = XW'(1) << SH;
    assign t    = r_in + bitv;
    assign ge   = x_in >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i] <= 1'b0;
      end else if (en) begin
        vv[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[i] <= ge ? x_in - t : x_in;
        rr[i] <= ge ? (r_in >> 1) + bitv : r_in >> 1;
        pp[i] <= p_in;
      end
    end
  end

  assign vo   = vv[Q-1];
  assign root = rr[Q-1];
  assign rem  = xr[Q-1];
  assign po   = pp[Q-1];

endmodule

`default_nettype wire

### src/refraction_direction.sv
`default_nettype none

// Snell refraction of one ray per beat.
// The input stream carries the incident vector, the surface normal (signed,
// FRAC_BITS fraction bits) and the indices of the two media (unsigned Q4.12).
// The output stream carries the transmitted vector, saturated to 18 bits,
// and in tuser the total internal reflection flag; on that flag the vector
// is zero. A zero destination index also reports total reflection.
// One beat can enter every cycle while the receiver takes results, and
// results leave in order, one per cycle. The pipeline is made of the two
// restoring dividers (32 + FRAC_BITS stages for eta^2), the square root
// (one root bit per stage) and the multiply and round stages.
// When the receiver stalls, the whole pipeline holds, and one more input
// beat is taken into a skid register before s_tready drops.
// Reset empties the pipeline and the skid register; no other state is kept.
module refraction_direction
  import rd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // in_x, in_y, in_z, norm_x, norm_y, norm_z, from_index, to_index
  input  wire logic [S_DATA_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // out_x, out_y, out_z, two zero bits
  output logic [M_DATA_W-1:0]      m_tdata,
  // total_reflection
  output logic                     m_tuser
);

  localparam int F     = FRAC_BITS;
  localparam int NW2   = 32 + F;
  localparam int EW    = 16 + F;
  localparam int E2W   = 32 + F;
  localparam int DOTW  = 34;
  localparam int CW    = 34 - F;
  localparam int KMW   = (2 * F + 1 > 2 * CW) ? 2 * F + 1 : 2 * CW;
  localparam int ETCW  = EW + 1 + CW;
  localparam int GAW   = ETCW - F + 1;
  localparam int MW    = ((KMW > E2W) ? KMW : E2W) + 1;
  localparam int PW    = E2W + KMW;
  localparam int SW    = 63 - F;
  localparam int Q     = (SW + 1) / 2;
  localparam int GW    = ((GAW > Q + 2) ? GAW : Q + 2) + 1;
  localparam int PEW   = EW + 17;
  localparam int PGW   = GW + 16;
  localparam int SUMW  = ((PEW > PGW) ? PEW : PGW) + 1;
  localparam int RNW   = SUMW - F + 1;
  localparam int DPW   = DOTW + VEC_W;
  localparam int SPW   = GAW + EW + VEC_W + 1;

  logic en;
  logic accept;

  // Input skid register.
  logic                skid_full;
  logic [S_DATA_W-1:0] skid_data;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = !skid_full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (accept) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && accept) begin
      skid_data <= s_tdata;
    end
  end

  // Stage 0: input register.
  logic                v0;
  logic [S_DATA_W-1:0] t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= skid_full || accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= skid_full ? skid_data : s_tdata;
    end
  end

  // Stage 1: products for the dot product and the squared indices.
  logic              v1;
  logic signed [31:0] pr1 [3];
  logic [31:0]        ff1;
  logic [31:0]        tt1;
  logic [IDX_W-1:0]   fr1;
  logic [IDX_W-1:0]   to1;
  logic [VEC_W-1:0]   vec1;
  logic               tz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pr1[j] <= $signed(t0[16*j +: 16]) * $signed(t0[48 + 16*j +: 16]);
      end
      ff1  <= t0[111:96] * t0[111:96];
      tt1  <= t0[127:112] * t0[127:112];
      fr1  <= t0[111:96];
      to1  <= t0[127:112];
      vec1 <= t0[VEC_W-1:0];
      tz1  <= t0[127:112] == '0;
    end
  end

  // Stage 2: dot product and rounded numerators.
  logic                   v2;
  logic signed [DOTW-1:0] dot2;
  logic [NW2-1:0]         num1_2;
  logic [NW2-1:0]         num2_2;
  logic [IDX_W-1:0]       den1_2;
  logic [31:0]            den2_2;
  logic [VEC_W-1:0]       vec2;
  logic                   tz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot2   <= DOTW'(pr1[0]) + DOTW'(pr1[1]) + DOTW'(pr1[2]);
      num1_2 <= NW2'({fr1, {F{1'b0}}}) + NW2'(to1[15:1]);
      num2_2 <= NW2'({ff1, {F{1'b0}}}) + NW2'(tt1[31:1]);
      den1_2 <= to1;
      den2_2 <= tt1;
      vec2   <= vec1;
      tz2    <= tz1;
    end
  end

  // Dividers for eta and eta^2, run side by side.
  logic           ev_o;
  logic           e2v_o;
  logic [NW2-1:0] eta_q;
  logic [NW2-1:0] eta2_q;
  logic [DPW-1:0] dp_o;
  logic           tz_o;

  rd_div #(
    .NW (NW2),
    .DW (IDX_W),
    .PW (DPW)
  ) u_div_eta (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .vi  (v2),
    .num (num1_2),
    .den (den1_2),
    .pi  ({dot2, vec2}),
    .vo  (ev_o),
    .quo (eta_q),
    .po  (dp_o)
  );

  rd_div #(
    .NW (NW2),
    .DW (32),
    .PW (1)
  ) u_div_eta2 (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .vi  (v2),
    .num (num2_2),
    .den (den2_2),
    .pi  (tz2),
    .vo  (e2v_o),
    .quo (eta2_q),
    .po  (tz_o)
  );

  // D1: c1 = round(-dot / 2^F).
  logic signed [DOTW-1:0] negd;
  logic                   nd_neg;
  logic [DOTW-1:0]        nd_mag;
  logic [DOTW:0]          c1_sum;
  logic [CW-1:0]          c1_m;

  assign negd   = -$signed(dp_o[DPW-1 -: DOTW]);
  assign nd_neg = negd[DOTW-1];
  assign nd_mag = nd_neg ? DOTW'(-negd) : DOTW'(negd);
  assign c1_sum = (DOTW + 1)'(nd_mag) + ((DOTW + 1)'(1) << (F - 1));
  assign c1_m   = CW'(c1_sum >> F);

  logic                 vd1;
  logic [EW-1:0]        eta_d1;
  logic [E2W-1:0]       eta2_d1;
  logic signed [CW-1:0] c1_d1;
  logic [VEC_W-1:0]     vec_d1;
  logic                 tz_d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd1 <= 1'b0;
    end else if (en) begin
      vd1 <= ev_o;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eta_d1  <= eta_q[EW-1:0];
      eta2_d1 <= eta2_q[E2W-1:0];
      c1_d1   <= nd_neg ? -$signed(c1_m) : $signed(c1_m);
      vec_d1  <= dp_o[VEC_W-1:0];
      tz_d1   <= tz_o;
    end
  end

  // D2: c1^2 and eta*c1.
  logic                     vd2;
  logic signed [2*CW-1:0]   c1sq_d2;
  logic signed [ETCW-1:0]   ec_d2;
  logic [EW-1:0]            eta_d2;
  logic [E2W-1:0]           eta2_d2;
  logic [VEC_W-1:0]         vec_d2;
  logic                     tz_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd2 <= 1'b0;
    end else if (en) begin
      vd2 <= vd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1sq_d2 <= c1_d1 * c1_d1;
      ec_d2   <= $signed({1'b0, eta_d1}) * c1_d1;
      eta_d2  <= eta_d1;
      eta2_d2 <= eta2_d1;
      vec_d2  <= vec_d1;
      tz_d2   <= tz_d1;
    end
  end

  // D3: k = 1 - c1^2 as sign and magnitude, and round(eta*c1 / 2^F).
  logic [KMW-1:0]  ka;
  logic [KMW-1:0]  kb;
  logic            ec_neg;
  logic [ETCW-1:0] ec_mag;
  logic [ETCW:0]   ec_sum;
  logic [GAW-1:0]  ga_m;

  assign ka     = KMW'(c1sq_d2[2*CW-2:0]);
  assign kb     = KMW'(1) << (2 * F);
  assign ec_neg = ec_d2[ETCW-1];
  assign ec_mag = ec_neg ? ETCW'(-ec_d2) : ETCW'(ec_d2);
  assign ec_sum = (ETCW + 1)'(ec_mag) + ((ETCW + 1)'(1) << (F - 1));
  assign ga_m   = GAW'(ec_sum >> F);

  logic                  vd3;
  logic                  kneg_d3;
  logic [KMW-1:0]        km_d3;
  logic signed [GAW-1:0] ga_d3;
  logic [EW-1:0]         eta_d3;
  logic [E2W-1:0]        eta2_d3;
  logic [VEC_W-1:0]      vec_d3;
  logic                  tz_d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd3 <= 1'b0;
    end else if (en) begin
      vd3 <= vd2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kneg_d3 <= ka > kb;
      km_d3   <= (ka > kb) ? ka - kb : kb - ka;
      ga_d3   <= ec_neg ? -$signed(ga_m) : $signed(ga_m);
      eta_d3  <= eta_d2;
      eta2_d3 <= eta2_d2;
      vec_d3  <= vec_d2;
      tz_d3   <= tz_d2;
    end
  end

  // D4: partial products of eta^2 * |k|.
  localparam int AHW = E2W - SPLIT;
  localparam int BHW = KMW - SPLIT;

  logic                  vd4;
  logic [2*SPLIT-1:0]    pll_d4;
  logic [KMW-1:0]        plh_d4;
  logic [E2W-1:0]        phl_d4;
  logic [AHW+BHW-1:0]    phh_d4;
  logic                  kneg_d4;
  logic signed [GAW-1:0] ga_d4;
  logic [EW-1:0]         eta_d4;
  logic [VEC_W-1:0]      vec_d4;
  logic                  tz_d4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd4 <= 1'b0;
    end else if (en) begin
      vd4 <= vd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll_d4  <= eta2_d3[SPLIT-1:0] * km_d3[SPLIT-1:0];
      plh_d4  <= eta2_d3[SPLIT-1:0] * km_d3[KMW-1:SPLIT];
      phl_d4  <= eta2_d3[E2W-1:SPLIT] * km_d3[SPLIT-1:0];
      phh_d4  <= eta2_d3[E2W-1:SPLIT] * km_d3[KMW-1:SPLIT];
      kneg_d4 <= kneg_d3;
      ga_d4   <= ga_d3;
      eta_d4  <= eta_d3;
      vec_d4  <= vec_d3;
      tz_d4   <= tz_d3;
    end
  end

  // D5: middle terms.
  logic                  vd5;
  logic [2*SPLIT-1:0]    pll_d5;
  logic [MW-1:0]         mid_d5;
  logic [AHW+BHW-1:0]    phh_d5;
  logic                  kneg_d5;
  logic signed [GAW-1:0] ga_d5;
  logic [EW-1:0]         eta_d5;
  logic [VEC_W-1:0]      vec_d5;
  logic                  tz_d5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd5 <= 1'b0;
    end else if (en) begin
      vd5 <= vd4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll_d5  <= pll_d4;
      mid_d5  <= MW'(plh_d4) + MW'(phl_d4);
      phh_d5  <= phh_d4;
      kneg_d5 <= kneg_d4;
      ga_d5   <= ga_d4;
      eta_d5  <= eta_d4;
      vec_d5  <= vec_d4;
      tz_d5   <= tz_d4;
    end
  end

  // D6: full product.
  logic                  vd6;
  logic [PW-1:0]         prod_d6;
  logic                  kneg_d6;
  logic signed [GAW-1:0] ga_d6;
  logic [EW-1:0]         eta_d6;
  logic [VEC_W-1:0]      vec_d6;
  logic                  tz_d6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd6 <= 1'b0;
    end else if (en) begin
      vd6 <= vd5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_d6 <= PW'(pll_d5) + (PW'(mid_d5) << SPLIT) + (PW'(phh_d5) << (2 * SPLIT));
      kneg_d6 <= kneg_d5;
      ga_d6   <= ga_d5;
      eta_d6  <= eta_d5;
      vec_d6  <= vec_d5;
      tz_d6   <= tz_d5;
    end
  end

  // D7: saturate the product magnitude.
  logic                  vd7;
  logic [SAT_SHIFT:0]    mag_d7;
  logic                  kneg_d7;
  logic signed [GAW-1:0] ga_d7;
  logic [EW-1:0]         eta_d7;
  logic [VEC_W-1:0]      vec_d7;
  logic                  tz_d7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd7 <= 1'b0;
    end else if (en) begin
      vd7 <= vd6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_d7  <= (prod_d6 > (PW'(1) << SAT_SHIFT)) ? (SAT_SHIFT + 1)'(1) << SAT_SHIFT
                                                   : prod_d6[SAT_SHIFT:0];
      kneg_d7 <= kneg_d6;
      ga_d7   <= ga_d6;
      eta_d7  <= eta_d6;
      vec_d7  <= vec_d6;
      tz_d7   <= tz_d6;
    end
  end

  // D8: cs3 = 1 - eta^2 * k; negative means total reflection.
  logic [63:0] base3;
  logic [63:0] cs3;

  assign base3 = 64'(1) << (3 * F);
  assign cs3   = kneg_d7 ? base3 + 64'(mag_d7) : base3 - 64'(mag_d7);

  logic                  vd8;
  logic [63:0]           cs3_d8;
  logic                  tir_d8;
  logic signed [GAW-1:0] ga_d8;
  logic [EW-1:0]         eta_d8;
  logic [VEC_W-1:0]      vec_d8;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd8 <= 1'b0;
    end else if (en) begin
      vd8 <= vd7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs3_d8 <= cs3;
      tir_d8 <= tz_d7 || cs3[63];
      ga_d8  <= ga_d7;
      eta_d8 <= eta_d7;
      vec_d8 <= vec_d7;
    end
  end

  // D9: cs2 = round(cs3 / 2^F).
  logic           vd9;
  logic [SW-1:0]  cs2_d9;
  logic [SPW-1:0] sp_d9;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd9 <= 1'b0;
    end else if (en) begin
      vd9 <= vd8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs2_d9 <= SW'((cs3_d8 + (64'(1) << (F - 1))) >> F);
      sp_d9  <= {ga_d8, eta_d8, vec_d8, tir_d8};
    end
  end

  // Square root of cs2.
  logic           sq_v;
  logic [SW:0]    sq_root;
  logic [SW:0]    sq_rem;
  logic [SPW-1:0] sq_p;

  rd_sqrt #(
    .SW (SW),
    .PW (SPW)
  ) u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vi   (vd9),
    .x    (cs2_d9),
    .pi   (sp_d9),
    .vo   (sq_v),
    .root (sq_root),
    .rem  (sq_rem),
    .po   (sq_p)
  );

  // E1: round the root to nearest.
  logic                  ve1;
  logic [Q:0]            s_e1;
  logic signed [GAW-1:0] ga_e1;
  logic [EW-1:0]         eta_e1;
  logic [VEC_W-1:0]      vec_e1;
  logic                  tir_e1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve1 <= 1'b0;
    end else if (en) begin
      ve1 <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_e1   <= sq_root[Q:0] + (Q + 1)'(sq_rem > sq_root);
      ga_e1  <= $signed(sq_p[SPW-1 -: GAW]);
      eta_e1 <= sq_p[VEC_W + EW -: EW];
      vec_e1 <= sq_p[VEC_W:1];
      tir_e1 <= sq_p[0];
    end
  end

  // E2: g = round(eta*c1) - s.
  logic                 ve2;
  logic signed [GW-1:0] g_e2;
  logic [EW-1:0]        eta_e2;
  logic [VEC_W-1:0]     vec_e2;
  logic                 tir_e2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve2 <= 1'b0;
    end else if (en) begin
      ve2 <= ve1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_e2   <= GW'(ga_e1) - $signed(GW'(s_e1));
      eta_e2 <= eta_e1;
      vec_e2 <= vec_e1;
      tir_e2 <= tir_e1;
    end
  end

  // E3: eta*I and g*N per component.
  logic                  ve3;
  logic signed [PEW-1:0] pe_e3 [3];
  logic signed [PGW-1:0] pg_e3 [3];
  logic                  tir_e3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve3 <= 1'b0;
    end else if (en) begin
      ve3 <= ve2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pe_e3[j] <= $signed({1'b0, eta_e2}) * $signed(vec_e2[16*j +: 16]);
        pg_e3[j] <= g_e2 * $signed(vec_e2[48 + 16*j +: 16]);
      end
      tir_e3 <= tir_e2;
    end
  end

  // E4: component sums.
  logic                   ve4;
  logic signed [SUMW-1:0] sum_e4 [3];
  logic                   tir_e4;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve4 <= 1'b0;
    end else if (en) begin
      ve4 <= ve3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sum_e4[j] <= SUMW'(pe_e3[j]) + SUMW'(pg_e3[j]);
      end
      tir_e4 <= tir_e3;
    end
  end

  // E5: round each component.
  logic            sm_neg [3];
  logic [SUMW-1:0] sm_mag [3];
  logic [SUMW:0]   sm_sum [3];
  logic [RNW-1:0]  sm_rs  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sm_neg[j] = sum_e4[j][SUMW-1];
      sm_mag[j] = sm_neg[j] ? SUMW'(-sum_e4[j]) : SUMW'(sum_e4[j]);
      sm_sum[j] = (SUMW + 1)'(sm_mag[j]) + ((SUMW + 1)'(1) << (F - 1));
      sm_rs[j]  = RNW'(sm_sum[j] >> F);
    end
  end

  logic                  ve5;
  logic signed [RNW-1:0] rn_e5 [3];
  logic                  tir_e5;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve5 <= 1'b0;
    end else if (en) begin
      ve5 <= ve4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        rn_e5[j] <= sm_neg[j] ? -$signed(sm_rs[j]) : $signed(sm_rs[j]);
      end
      tir_e5 <= tir_e4;
    end
  end

  // E6: saturate into the output register; total reflection gives zero.
  logic [OUT_W-1:0] sat [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (tir_e5) begin
        sat[j] = '0;
      end else if (rn_e5[j] > RNW'(OUT_MAX)) begin
        sat[j] = OUT_W'(OUT_MAX);
      end else if (rn_e5[j] < RNW'(OUT_MIN)) begin
        sat[j] = OUT_W'(OUT_MIN);
      end else begin
        sat[j] = rn_e5[j][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ve5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {2'b00, sat[2], sat[1], sat[0]};
      m_tuser <= tir_e5;
    end
  end

  // The two dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) ev_o == e2v_o)
    else $error("eta and eta^2 dividers out of step");

  // A reflected ray carries a zero vector.
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[3*OUT_W-1:0] == '0)
    else $error("total reflection with nonzero vector");

  // The skid register fills only from a beat taken during a stall.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(accept && !en))
    else $error("skid register filled without a stalled beat");

  // While the pipeline holds, the skid register keeps its beat.
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_full && !en |=> skid_full)
    else $error("skid beat lost during stall");

endmodule

`default_nettype wire
